/* hdl/assert_macros.svh */
// Assertion helpers shared by the RTL. Each macro expects clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// A property that must hold at every clock edge outside reset.
`define ASSERT_PROP(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// A condition that must never be seen at a clock edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define ASSERT_PROP(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)

`endif

`endif

/* hdl/lked_pkg.sv */
package lked_pkg;

  // Converter resolution and the debounce length.
  localparam int ADC_BITS         = 12;
  localparam int DEBOUNCE_SAMPLES = 3;
  localparam int CNT_BITS         = $clog2(DEBOUNCE_SAMPLES + 1);

  localparam int MS_BITS       = 16;
  localparam int TIME_BITS     = 32;
  localparam int EVT_BITS      = 4;
  localparam int KEY_BITS      = 2;
  localparam int NUM_KEYS      = 3;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = (ADC_BITS > MS_BITS) ? ADC_BITS : MS_BITS;

  // Decoded key codes.
  typedef enum logic [KEY_BITS-1:0] {
    KEY_IDLE  = 2'd0,
    KEY_USR   = 2'd1,
    KEY_LEFT  = 2'd2,
    KEY_RIGHT = 2'd3
  } key_code_t;

  // Per-key slot numbers.
  localparam int SLOT_LEFT  = 0;
  localparam int SLOT_RIGHT = 1;
  localparam int SLOT_USER  = 2;

  // Bit positions inside an event nibble.
  localparam int EVT_PRESS  = 0;
  localparam int EVT_LONG   = 1;
  localparam int EVT_REPEAT = 2;
  localparam int EVT_SHORT  = 3;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_USER_HIGH  = 3'd0,
    CFG_LEFT_LOW   = 3'd1,
    CFG_LEFT_HIGH  = 3'd2,
    CFG_RIGHT_LOW  = 3'd3,
    CFG_RIGHT_HIGH = 3'd4,
    CFG_LONG_MS    = 3'd5,
    CFG_REPEAT_MS  = 3'd6
  } cfg_reg_t;

  // Reset values: the ladder voltage limits on a 7.2 V / 4096 scale, and times in ms.
  localparam logic [ADC_BITS-1:0] USER_HIGH_RST  = ADC_BITS'(199);
  localparam logic [ADC_BITS-1:0] LEFT_LOW_RST   = ADC_BITS'(228);
  localparam logic [ADC_BITS-1:0] LEFT_HIGH_RST  = ADC_BITS'(426);
  localparam logic [ADC_BITS-1:0] RIGHT_LOW_RST  = ADC_BITS'(456);
  localparam logic [ADC_BITS-1:0] RIGHT_HIGH_RST = ADC_BITS'(682);
  localparam logic [MS_BITS-1:0]  LONG_MS_RST    = MS_BITS'(500);
  localparam logic [MS_BITS-1:0]  REPEAT_MS_RST  = MS_BITS'(200);

endpackage

/* hdl/ladder_key_event_detector.sv */
// Ladder key event detector. Each beat on the input channel carries one converter
// sample from a resistor-ladder key line, a conversion-ok flag and a millisecond
// timestamp; each beat produces exactly one result beat with the decoded key
// (none, user, left or right) and a nibble of events for each of the three keys:
// press, long press, auto-repeat and short release. A failed conversion reads as
// no key. Every key is debounced over four equal samples, and hold and repeat
// times are measured as timestamp differences that wrap modulo 2^32. The block
// takes one sample per clock cycle while the result channel does not stall; a
// sample is first captured in an input register, and the decode and per-key state
// update then run combinationally into the result register, which is written only
// when it can take a new beat. That state update is what sets the rate, since
// each sample needs the debounce and timer state left by the one before it. The
// seven threshold and timing registers are written through the plain write port;
// the user must write them only while the block is idle, which the block itself
// does not enforce. They come out of reset at the package defaults: the voltage
// limits of the ladder scheme and the hold and repeat times.
module ladder_key_event_detector (
  input  logic                                   clk,
  input  logic                                   rst,
  // Sample channel.
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [lked_pkg::ADC_BITS-1:0]          adc_sample,
  input  logic                                   sample_ok,
  input  logic [lked_pkg::TIME_BITS-1:0]         now_ms,
  // Result channel.
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [lked_pkg::KEY_BITS-1:0]          key_code,
  output logic [lked_pkg::EVT_BITS-1:0]          left_events,
  output logic [lked_pkg::EVT_BITS-1:0]          right_events,
  output logic [lked_pkg::EVT_BITS-1:0]          user_events,
  // Configuration write port.
  input  logic                                   cfg_write,
  input  logic [lked_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  logic [lked_pkg::CFG_DATA_BITS-1:0]     cfg_data
);
  import lked_pkg::*;

  `include "assert_macros.svh"

  // Configuration registers.
  logic [ADC_BITS-1:0] user_high;
  logic [ADC_BITS-1:0] left_low;
  logic [ADC_BITS-1:0] left_high;
  logic [ADC_BITS-1:0] right_low;
  logic [ADC_BITS-1:0] right_high;
  logic [MS_BITS-1:0]  hold_ms;
  logic [MS_BITS-1:0]  repeat_ms;

  // Input register stage.
  logic                 in_full;
  logic [ADC_BITS-1:0]  sample_q;
  logic                 ok_q;
  logic [TIME_BITS-1:0] now_q;
  logic                 advance;

  // Per-key state. Level bits use 1 for released and 0 for pressed.
  logic [NUM_KEYS-1:0]  stable_level;
  logic [NUM_KEYS-1:0]  previous_raw;
  logic [CNT_BITS-1:0]  stable_count [NUM_KEYS];
  logic [NUM_KEYS-1:0]  held_flag;
  logic [NUM_KEYS-1:0]  long_done;
  logic [TIME_BITS-1:0] press_time [NUM_KEYS];
  logic [TIME_BITS-1:0] last_repeat_time [NUM_KEYS];

  logic [NUM_KEYS-1:0]  stable_level_next;
  logic [CNT_BITS-1:0]  stable_count_next [NUM_KEYS];
  logic [NUM_KEYS-1:0]  held_flag_next;
  logic [NUM_KEYS-1:0]  long_done_next;
  logic [TIME_BITS-1:0] press_time_next [NUM_KEYS];
  logic [TIME_BITS-1:0] last_repeat_time_next [NUM_KEYS];

  // Per-key working values of the update.
  key_code_t            key_next;
  logic [NUM_KEYS-1:0]  pressed;
  logic [NUM_KEYS-1:0]  raw;
  logic [NUM_KEYS-1:0]  change;
  logic [NUM_KEYS-1:0]  press_evt;
  logic [NUM_KEYS-1:0]  short_evt;
  logic [NUM_KEYS-1:0]  long_evt;
  logic [NUM_KEYS-1:0]  repeat_evt;
  logic [NUM_KEYS-1:0]  long_mid;
  logic [TIME_BITS-1:0] long_diff [NUM_KEYS];
  logic [TIME_BITS-1:0] repeat_diff [NUM_KEYS];
  logic [EVT_BITS-1:0]  events_next [NUM_KEYS];

  // True when a wrapped time difference has reached a 16-bit millisecond limit.
  function automatic logic reached(input logic [TIME_BITS-1:0] diff,
                                   input logic [MS_BITS-1:0] limit);
    logic upper;
    upper = |diff[TIME_BITS-1:MS_BITS];
    return upper || (diff[MS_BITS-1:0] >= limit);
  endfunction

  // The input register passes its beat on whenever it holds one and the result register can take a new beat.
  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  // Key decode: user first, then left, then right; empty ranges never match.
  always_comb begin
    key_next = KEY_IDLE;
    if (ok_q) begin
      if (sample_q <= user_high) begin
        key_next = KEY_USR;
      end else if (sample_q >= left_low && sample_q <= left_high) begin
        key_next = KEY_LEFT;
      end else if (sample_q >= right_low && sample_q <= right_high) begin
        key_next = KEY_RIGHT;
      end
    end
    pressed[SLOT_LEFT]  = (key_next == KEY_LEFT);
    pressed[SLOT_RIGHT] = (key_next == KEY_RIGHT);
    pressed[SLOT_USER]  = (key_next == KEY_USR);
  end

  // Debounce and event logic, one independent copy per key.
  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      raw[k] = !pressed[k];

      // A raw level that differs from the last one restarts the count.
      if (raw[k] != previous_raw[k]) begin
        stable_count_next[k] = '0;
      end else if (stable_count[k] < CNT_BITS'(DEBOUNCE_SAMPLES)) begin
        stable_count_next[k] = stable_count[k] + CNT_BITS'(1);
      end else begin
        stable_count_next[k] = stable_count[k];
      end

      change[k]    = (stable_count_next[k] == CNT_BITS'(DEBOUNCE_SAMPLES)) &&
                     (raw[k] != stable_level[k]);
      press_evt[k] = change[k] && !raw[k];
      short_evt[k] = change[k] && raw[k] && held_flag[k] && !long_done[k];

      stable_level_next[k] = change[k] ? raw[k] : stable_level[k];
      if (press_evt[k]) begin
        held_flag_next[k] = 1'b1;
      end else if (change[k]) begin
        held_flag_next[k] = 1'b0;
      end else begin
        held_flag_next[k] = held_flag[k];
      end
      long_mid[k] = press_evt[k] ? 1'b0 : long_done[k];

      // On the press itself both timers restart at this sample, so the
      // elapsed time is zero.
      long_diff[k] = press_evt[k] ? '0 : (now_q - press_time[k]);
      long_evt[k]  = held_flag_next[k] && !long_mid[k] &&
                     reached(long_diff[k], hold_ms);
      long_done_next[k] = long_mid[k] || long_evt[k];

      repeat_diff[k] = (press_evt[k] || long_evt[k]) ? '0 : (now_q - last_repeat_time[k]);
      repeat_evt[k]  = held_flag_next[k] && long_done_next[k] &&
                       reached(repeat_diff[k], repeat_ms);

      press_time_next[k]       = press_evt[k] ? now_q : press_time[k];
      last_repeat_time_next[k] = (press_evt[k] || long_evt[k] || repeat_evt[k]) ?
                                 now_q : last_repeat_time[k];

      events_next[k] = '0;
      events_next[k][EVT_PRESS]  = press_evt[k];
      events_next[k][EVT_LONG]   = long_evt[k];
      events_next[k][EVT_REPEAT] = repeat_evt[k];
      events_next[k][EVT_SHORT]  = short_evt[k];
    end
  end

  // Control state, configuration and per-key flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full       <= 1'b0;
      out_valid     <= 1'b0;
      user_high     <= USER_HIGH_RST;
      left_low      <= LEFT_LOW_RST;
      left_high     <= LEFT_HIGH_RST;
      right_low     <= RIGHT_LOW_RST;
      right_high    <= RIGHT_HIGH_RST;
      hold_ms       <= LONG_MS_RST;
      repeat_ms     <= REPEAT_MS_RST;
      stable_level  <= '1;
      previous_raw  <= '1;
      held_flag     <= '0;
      long_done     <= '0;
      for (int k = 0; k < NUM_KEYS; k++) begin
        stable_count[k] <= CNT_BITS'(DEBOUNCE_SAMPLES);
      end
    end else begin
      if (in_valid && in_ready) begin
        in_full <= 1'b1;
      end else if (advance) begin
        in_full <= 1'b0;
      end

      if (advance) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (advance) begin
        stable_level <= stable_level_next;
        previous_raw <= raw;
        held_flag    <= held_flag_next;
        long_done    <= long_done_next;
        for (int k = 0; k < NUM_KEYS; k++) begin
          stable_count[k] <= stable_count_next[k];
        end
      end

      if (cfg_write) begin
        case (cfg_index)
          CFG_USER_HIGH:  user_high     <= cfg_data[ADC_BITS-1:0];
          CFG_LEFT_LOW:   left_low      <= cfg_data[ADC_BITS-1:0];
          CFG_LEFT_HIGH:  left_high     <= cfg_data[ADC_BITS-1:0];
          CFG_RIGHT_LOW:  right_low     <= cfg_data[ADC_BITS-1:0];
          CFG_RIGHT_HIGH: right_high    <= cfg_data[ADC_BITS-1:0];
          CFG_LONG_MS:    hold_ms       <= cfg_data[MS_BITS-1:0];
          CFG_REPEAT_MS:  repeat_ms     <= cfg_data[MS_BITS-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: the captured sample, the timestamps and the result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      sample_q <= adc_sample;
      ok_q     <= sample_ok;
      now_q    <= now_ms;
    end
    if (advance) begin
      key_code     <= key_next;
      left_events  <= events_next[SLOT_LEFT];
      right_events <= events_next[SLOT_RIGHT];
      user_events  <= events_next[SLOT_USER];
      for (int k = 0; k < NUM_KEYS; k++) begin
        press_time[k]       <= press_time_next[k];
        last_repeat_time[k] <= last_repeat_time_next[k];
      end
    end
  end

  // A beat that leaves the input register always lands in the result register.
  `ASSERT_PROP(a_advance_lands, advance |=> out_valid, "processed beat did not reach the result")
  // A captured sample that cannot move on is kept, timestamp and all.
  `ASSERT_PROP(a_hold_input, (in_full && !advance) |=> (in_full && $stable(now_q)),
    "waiting sample was lost or changed")
  // A key is held exactly while its debounced level reads pressed.
  `ASSERT_PROP(a_held_matches_level, held_flag == ~stable_level,
    "held flag out of step with the debounced level")
  // Press and short release are opposite level changes and never share a result.
  `ASSERT_NEVER(a_press_short_left, out_valid && left_events[EVT_PRESS] &&
    left_events[EVT_SHORT], "left key reports press and short release together")

endmodule
